[hdl/ring_buffer_queue_with_threshold_macros.svh]
// Assertion macros for the ring buffer queue checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RING_BUFFER_QUEUE_WITH_THRESHOLD_MACROS_SVH
`define RING_BUFFER_QUEUE_WITH_THRESHOLD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RBQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rbq_pkg.sv]
// Shared types and constants for the ring buffer queue with threshold.
// No dependencies; used by the controller, datapath, top level and checker.
package rbq_pkg;

  // Storage geometry
  localparam int DEPTH     = 16;
  localparam int MSG_WIDTH = 32;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths fixed by the interface
  localparam int CNT_W     = 5;
  localparam int CFG_W     = 5;
  localparam int MSG_OUT_W = 32;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CFG_W-1:0] THR_RESET = 5'd0;

  // Action codes
  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_GET = 1'b1;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } rbq_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // latch the accepted item
    logic exec;   // perform the operation and load the result registers
  } rbq_cmd_t;

endpackage

[hdl/rbq_ctrl.sv]
// Controller for the ring buffer queue: item sequencing and result handshake.
// Depends on rbq_pkg; drives commands into rbq_dp.
module rbq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output rbq_pkg::rbq_cmd_t cmd
);

  rbq_pkg::rbq_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r;
    // drop the result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      rbq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rbq_pkg::ST_EXEC;
        end
      end
      rbq_pkg::ST_EXEC: begin
        // hold until the result register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rbq_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/rbq_dp.sv]
// Datapath for the ring buffer queue: configuration, pointers, count, slot memory
// and result registers. Depends on rbq_pkg; commanded by rbq_ctrl.
module rbq_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rbq_pkg::rbq_cmd_t               cmd,
  input  logic                            in_action,
  input  logic [31:0]                     in_msg_in,
  input  logic                            cfg_we,
  input  logic [rbq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbq_pkg::CFG_W-1:0]       cfg_data,
  output logic                            out_ok,
  output logic [rbq_pkg::MSG_OUT_W-1:0]   out_msg_out,
  output logic [rbq_pkg::CNT_W-1:0]       out_fill_count
);

  // Advance an index by one slot, wrapping at the capacity in use
  function automatic logic [rbq_pkg::IDX_W-1:0] next_idx(
    input logic [rbq_pkg::IDX_W-1:0] idx,
    input logic [rbq_pkg::CNT_W-1:0] cap
  );
    logic [rbq_pkg::CNT_W-1:0] inc;
    inc = rbq_pkg::CNT_W'(idx) + rbq_pkg::CNT_W'(1);
    next_idx = (inc >= cap) ? '0 : rbq_pkg::IDX_W'(inc);
  endfunction

  logic [rbq_pkg::CFG_W-1:0]     cap_r, thr_r;
  logic [rbq_pkg::IDX_W-1:0]     wr_idx_r, rd_idx_r, wr_idx_nxt, rd_idx_nxt;
  logic [rbq_pkg::CNT_W-1:0]     stored_r, stored_nxt;
  logic                          act_r;
  logic [31:0]                   msg_r;
  logic [rbq_pkg::MSG_WIDTH-1:0] mem [rbq_pkg::DEPTH];
  logic [rbq_pkg::MSG_OUT_W-1:0] rd_data_r;
  logic                          ok_r;
  logic [rbq_pkg::CNT_W-1:0]     fill_r;
  logic [rbq_pkg::CNT_W-1:0]     cap_use;
  logic                          put_ok, get_ok;

  // Capacity in use saturates at the memory depth
  assign cap_use = (rbq_pkg::CNT_W'(cap_r) > rbq_pkg::CNT_W'(rbq_pkg::DEPTH)) ?
                   rbq_pkg::CNT_W'(rbq_pkg::DEPTH) : rbq_pkg::CNT_W'(cap_r);

  // Decide success of the latched item
  assign put_ok = (cap_use != '0) && (act_r == rbq_pkg::ACT_PUT) && (stored_r < cap_use);
  assign get_ok = (cap_use != '0) && (act_r == rbq_pkg::ACT_GET) &&
                  (stored_r > rbq_pkg::CNT_W'(thr_r));

  // Next pointers and count
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    stored_nxt = stored_r;
    if (put_ok) begin
      wr_idx_nxt = next_idx(wr_idx_r, cap_use);
      stored_nxt = stored_r + rbq_pkg::CNT_W'(1);
    end else if (get_ok) begin
      rd_idx_nxt = next_idx(rd_idx_r, cap_use);
      stored_nxt = stored_r - rbq_pkg::CNT_W'(1);
    end
  end

  // Configuration and queue control state; a register write empties the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= rbq_pkg::CAP_RESET;
      thr_r    <= rbq_pkg::THR_RESET;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      stored_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbq_pkg::REG_CAPACITY:  cap_r <= cfg_data;
        rbq_pkg::REG_THRESHOLD: thr_r <= cfg_data;
      endcase
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      stored_r <= '0;
    end else if (cmd.exec) begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      stored_r <= stored_nxt;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      msg_r <= in_msg_in;
    end
  end

  // Slot memory with registered read; read data doubles as the message result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (put_ok) begin
        mem[wr_idx_r] <= rbq_pkg::MSG_WIDTH'(msg_r);
      end
      rd_data_r <= get_ok ? rbq_pkg::MSG_OUT_W'(mem[rd_idx_r]) : '0;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r   <= put_ok | get_ok;
      fill_r <= stored_nxt;
    end
  end

  assign out_ok         = ok_r;
  assign out_msg_out    = rd_data_r;
  assign out_fill_count = fill_r;

endmodule

[hdl/ring_buffer_queue_with_threshold.sv]
// Circular FIFO of 32-bit messages with a configurable capacity (register 0, reset
// 16, saturates at 16 slots, zero refuses every access) and hold threshold
// (register 1, reset 0; a get succeeds only while more than that many messages are
// stored). Each item is a put (action 0) or a get (action 1) and yields one result:
// ok, the oldest message on a successful get (zero otherwise) and the count after
// the operation. An item is latched in the idle state, then in the execute state
// updates the pointers, the count and the slot memory, whose registered read port
// holds the result message. The update waits while an earlier result is stalled
// at the output. Writing either register empties the queue; cfg_ready is always
// high and writes are expected only while the block is idle. Depends on rbq_pkg.
module ring_buffer_queue_with_threshold (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [31:0]                   in_msg_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic [rbq_pkg::MSG_OUT_W-1:0] out_msg_out,
  output logic [rbq_pkg::CNT_W-1:0]     out_fill_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbq_pkg::CFG_W-1:0]     cfg_data
);

  rbq_pkg::rbq_cmd_t cmd;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  rbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rbq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_action      (in_action),
    .in_msg_in      (in_msg_in),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ok         (out_ok),
    .out_msg_out    (out_msg_out),
    .out_fill_count (out_fill_count)
  );

endmodule

[hdl/rbq_checker.sv]
// Port-level checker for the ring buffer queue, bound to the top level.
// Depends on rbq_pkg and ring_buffer_queue_with_threshold_macros.svh.
`include "ring_buffer_queue_with_threshold_macros.svh"

module rbq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_ok,
  input logic [rbq_pkg::MSG_OUT_W-1:0] out_msg_out,
  input logic [rbq_pkg::CNT_W-1:0]     out_fill_count
);

  logic                                        held;
  logic [rbq_pkg::MSG_OUT_W+rbq_pkg::CNT_W:0] res;
  logic                                        fill_over;

  // Result waiting under stall, the whole result item, count above the slot count
  assign held      = out_valid && out_stall;
  assign res       = {out_ok, out_msg_out, out_fill_count};
  assign fill_over = out_fill_count > rbq_pkg::CNT_W'(rbq_pkg::DEPTH);

  // A stalled result stays valid
  `RBQ_ASSERT_NEXT(a_out_hold, clk, rst_n, held, out_valid, "result dropped while stalled")

  // A stalled result does not change
  `RBQ_ASSERT_NEXT(a_out_stable, clk, rst_n, held, $stable(res), "stalled result changed")

  // A refused access returns no message
  `RBQ_ASSERT_NOW(a_msg_zero, clk, rst_n, out_valid && !out_ok, out_msg_out == '0, "msg on refusal")

  // The count never exceeds the slot count
  `RBQ_ASSERT_NOW(a_fill_max, clk, rst_n, out_valid, !fill_over, "count above depth")

endmodule

bind ring_buffer_queue_with_threshold rbq_checker u_rbq_checker (.*);

[dv/tb_ring_buffer_queue_with_threshold.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the ring buffer queue with threshold: drives puts, gets and
// register writes, predicts each result in a small class and compares it field by field.
// Depends on rbq_pkg and the ring_buffer_queue_with_threshold top level.

// Predicted result of one put or get
typedef struct packed {
  logic                          ok;
  logic [rbq_pkg::MSG_OUT_W-1:0] msg;
  logic [rbq_pkg::CNT_W-1:0]     fill;
} access_resp_t;

// Queue predictor and result checker
class fifo_checker;
  logic [rbq_pkg::MSG_WIDTH-1:0] slots [rbq_pkg::DEPTH];
  int unsigned                   wr_ptr;
  int unsigned                   rd_ptr;
  int unsigned                   fill;
  int unsigned                   capacity;
  int unsigned                   threshold;
  access_resp_t                  expected_resp [$];
  int unsigned                   errors;

  function new();
    wr_ptr    = 0;
    rd_ptr    = 0;
    fill      = 0;
    capacity  = 32'(rbq_pkg::CAP_RESET);
    threshold = 32'(rbq_pkg::THR_RESET);
    errors    = 0;
  endfunction

  // Apply a register write: set the register and empty the queue, keep slot contents
  function void write_reg(logic [rbq_pkg::CFG_IDX_W-1:0] idx, logic [rbq_pkg::CFG_W-1:0] val);
    if (idx == rbq_pkg::REG_CAPACITY) begin
      capacity = 32'(val);
    end else begin
      threshold = 32'(val);
    end
    wr_ptr = 0;
    rd_ptr = 0;
    fill   = 0;
  endfunction

  // Predict the result of one accepted item and queue it
  function void note_access(logic act, logic [31:0] msg);
    access_resp_t r;
    int unsigned  cap;
    cap = (capacity > rbq_pkg::DEPTH) ? rbq_pkg::DEPTH : capacity;
    r   = '0;
    if (cap != 0) begin
      if (act == rbq_pkg::ACT_PUT) begin
        if (fill < cap) begin
          slots[wr_ptr] = msg;
          wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
          fill++;
          r.ok = 1'b1;
        end
      end else if (fill > threshold) begin
        r.msg  = slots[rd_ptr];
        rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
        fill--;
        r.ok = 1'b1;
      end
    end
    r.fill = fill[rbq_pkg::CNT_W-1:0];
    expected_resp.push_back(r);
  endfunction

  // Compare one accepted result with the oldest prediction
  function void check_response(logic ok, logic [rbq_pkg::MSG_OUT_W-1:0] msg,
                               logic [rbq_pkg::CNT_W-1:0] fill_o);
    access_resp_t exp_r;
    if (expected_resp.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result ok=%0b msg=%h fill=%0d", $time, ok, msg, fill_o);
      return;
    end
    exp_r = expected_resp.pop_front();
    if (ok !== exp_r.ok || msg !== exp_r.msg || fill_o !== exp_r.fill) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch: expected ok=%0b msg=%h fill=%0d, got ok=%0b msg=%h fill=%0d",
                 $time, exp_r.ok, exp_r.msg, exp_r.fill, ok, msg, fill_o);
    end
  endfunction

  function int unsigned pending();
    return expected_resp.size();
  endfunction
endclass

module tb_ring_buffer_queue_with_threshold;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SEG_ITEMS      = 85;
  localparam int NUM_SEGS       = 12;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_action;
  logic [31:0]                   in_msg_in;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_ok;
  logic [rbq_pkg::MSG_OUT_W-1:0] out_msg_out;
  logic [rbq_pkg::CNT_W-1:0]     out_fill_count;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rbq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rbq_pkg::CFG_W-1:0]     cfg_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;

  // Register settings per random segment: extremes, saturation, threshold at or over capacity
  int unsigned seg_cap [NUM_SEGS] = '{16, 1, 31, 0, 4, 16, 2, 17, 8, 16, 3, 5};
  int unsigned seg_thr [NUM_SEGS] = '{0, 0, 31, 0, 2, 15, 1, 0, 8, 3, 0, 16};

  fifo_checker sb = new();

  ring_buffer_queue_with_threshold u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_msg_in      (in_msg_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_msg_out    (out_msg_out),
    .out_fill_count (out_fill_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Observe handshakes, feed the predictor and check results; watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_access(in_action, in_msg_in);
      if (out_valid && !out_stall) sb.check_response(out_ok, out_msg_out, out_fill_count);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Present one item, hold it until accepted; called and returning at a falling edge
  task automatic send_item(input logic act, input logic [31:0] msg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_action = act;
    in_msg_in = msg;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted result has arrived
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input logic [rbq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rbq_pkg::CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input int unsigned cap, input int unsigned thr);
    drain();
    write_reg(rbq_pkg::REG_CAPACITY, cap[rbq_pkg::CFG_W-1:0]);
    write_reg(rbq_pkg::REG_THRESHOLD, thr[rbq_pkg::CFG_W-1:0]);
  endtask

  initial begin
    int unsigned put_pct;
    int unsigned seg;
    logic [31:0] msg;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = rbq_pkg::ACT_PUT;
    in_msg_in = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = rbq_pkg::REG_CAPACITY;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: get from empty, field extremes, drain to empty again
    send_item(rbq_pkg::ACT_GET, 32'h1234_5678);
    send_item(rbq_pkg::ACT_PUT, 32'h0000_0000);
    send_item(rbq_pkg::ACT_PUT, 32'hFFFF_FFFF);
    send_item(rbq_pkg::ACT_GET, 32'h0);
    send_item(rbq_pkg::ACT_GET, 32'hFFFF_FFFF);
    send_item(rbq_pkg::ACT_GET, 32'h0);

    // Zero capacity: refuse everything
    set_regs(0, 0);
    send_item(rbq_pkg::ACT_PUT, 32'hA5A5_A5A5);
    send_item(rbq_pkg::ACT_GET, 32'h0);

    // Two slots: refuse put when full, wrap both pointers, refuse get when empty
    set_regs(2, 0);
    send_item(rbq_pkg::ACT_PUT, 32'h1111_1111);
    send_item(rbq_pkg::ACT_PUT, 32'h2222_2222);
    send_item(rbq_pkg::ACT_PUT, 32'h3333_3333);
    send_item(rbq_pkg::ACT_GET, 32'h0);
    send_item(rbq_pkg::ACT_PUT, 32'h4444_4444);
    send_item(rbq_pkg::ACT_GET, 32'h0);
    send_item(rbq_pkg::ACT_GET, 32'h0);
    send_item(rbq_pkg::ACT_GET, 32'h0);

    // Capacity beyond the slot count saturates; gets stop at the threshold
    set_regs(31, 3);
    send_item(rbq_pkg::ACT_PUT, 32'h5A5A_5A5A);
    send_item(rbq_pkg::ACT_PUT, 32'h8000_0001);
    send_item(rbq_pkg::ACT_PUT, 32'h7FFF_FFFE);
    send_item(rbq_pkg::ACT_PUT, 32'hDEAD_BEEF);
    send_item(rbq_pkg::ACT_GET, 32'h0);
    send_item(rbq_pkg::ACT_GET, 32'h0);

    // Threshold equal to capacity: no get succeeds
    set_regs(2, 2);
    send_item(rbq_pkg::ACT_PUT, 32'hCAFE_F00D);
    send_item(rbq_pkg::ACT_PUT, 32'h0BAD_C0DE);
    send_item(rbq_pkg::ACT_GET, 32'h0);

    // Random segments across idle modes and register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int k = 0; k < 3; k++) begin
        seg = ph * 3 + k;
        set_regs(seg_cap[seg], seg_thr[seg]);
        put_pct = 75;
        for (int i = 0; i < SEG_ITEMS; i++) begin
          // Swing the fill level between bursts of puts and bursts of gets
          if ($urandom_range(11) == 0) put_pct = 100 - put_pct;
          case ($urandom_range(9))
            0:       msg = 32'h0000_0000;
            1:       msg = 32'hFFFF_FFFF;
            default: msg = $urandom;
          endcase
          if (i == SEG_ITEMS / 2) drain();
          send_item(($urandom_range(99) < put_pct) ? rbq_pkg::ACT_PUT : rbq_pkg::ACT_GET, msg);
        end
      end
    end

    // Wait out the tail and report
    drain();
    repeat (10) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hdl
hdl/rbq_pkg.sv
hdl/rbq_ctrl.sv
hdl/rbq_dp.sv
hdl/ring_buffer_queue_with_threshold.sv
hdl/rbq_checker.sv
dv/tb_ring_buffer_queue_with_threshold.sv
